// ===== rtl/core/sldq_pkg.sv =====
// Shared types and codes for the sorted list deque engine.
package sldq_pkg;

	localparam int HANDLE_W = 8;
	localparam int VALUE_W  = 32;
	localparam int REQ_W    = 3;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_INSERT     = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd6;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_DUP      = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_EXEC = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

endpackage

// ===== rtl/core/sldq_ctrl.sv =====
// Request sequencer: captures a beat, then commits it once the result register is free.
module sldq_ctrl import sldq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_nx;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nx    = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_nx = CS_EXEC;
				end
			end
			CS_EXEC: begin
				// hold the list update until the previous result has gone
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_nx   = CS_IDLE;
				end
			end
			default: begin
				state_nx = CS_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/sldq_dp.sv =====
// List cells, per-cell comparators, shift network and result registers.
module sldq_dp import sldq_pkg::*; #(
	parameter int CAPACITY     = 16,
	parameter int HANDLE_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [VALUE_W-1:0]  value,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [VALUE_W-1:0]  out_value,
	output logic [OCC_W-1:0]    occupancy,
	output logic                is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CAPACITY-1:0] ONE_HOT0 = CAPACITY'(1);

	logic [VALUE_W-1:0]  val_q [CAPACITY];
	logic [HANDLE_W-1:0] hdl_q [CAPACITY];
	logic [VALUE_W-1:0]  val_nx [CAPACITY];
	logic [HANDLE_W-1:0] hdl_nx [CAPACITY];
	logic [VALUE_W-1:0]  prv_v [CAPACITY];
	logic [HANDLE_W-1:0] prv_h [CAPACITY];
	logic [VALUE_W-1:0]  nxt_v [CAPACITY];
	logic [HANDLE_W-1:0] nxt_h [CAPACITY];
	logic [CW-1:0]       cnt_q, cnt_nx;
	logic                order_q;

	// request and compare flags, first cycle
	logic [REQ_W-1:0]    req_s1;
	logic [HANDLE_W-1:0] hdl_s1;
	logic [VALUE_W-1:0]  val_s1;
	logic                hbad_s1;
	logic [CAPACITY-1:0] hmatch_s1, after_s1, vmatch_s1;
	logic [CAPACITY-1:0] hmatch_c, after_c, vmatch_c;

	// result registers
	status_t             status_q, st;
	logic [HANDLE_W-1:0] oh_q, oh;
	logic [VALUE_W-1:0]  ov_q, ov;
	logic [OCC_W-1:0]    occ_q;
	logic                empty_q;

	logic [CAPACITY-1:0] hfirst, afirst, vfirst, cnt_oh, last_oh;
	logic [CAPACITY-1:0] ins_oh, take_oh, rd_oh, mask_le, mask_lt;
	logic                do_ins, do_take, rd_en, full, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_wr_en) begin
			order_q <= cfg_wr_data;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic live;
		assign live        = CW'(g) < cnt_q;
		assign hmatch_c[g] = live && (hdl_q[g] == handle);
		assign vmatch_c[g] = live && (val_q[g] == value);
		assign after_c[g]  = live && (order_q ? (val_q[g] < value) : (val_q[g] > value));
		if (g == 0) begin : g_first
			assign prv_v[g] = val_q[g];
			assign prv_h[g] = hdl_q[g];
		end else begin : g_mid
			assign prv_v[g] = val_q[g-1];
			assign prv_h[g] = hdl_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign nxt_v[g] = val_q[g];
			assign nxt_h[g] = hdl_q[g];
		end else begin : g_body
			assign nxt_v[g] = val_q[g+1];
			assign nxt_h[g] = hdl_q[g+1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_s1    <= req_type;
			hdl_s1    <= handle;
			val_s1    <= value;
			hbad_s1   <= {{(32-HANDLE_W){1'b0}}, handle} >= 32'(HANDLE_COUNT);
			hmatch_s1 <= hmatch_c;
			after_s1  <= after_c;
			vmatch_s1 <= vmatch_c;
		end
	end

	// lowest set bit of each flag vector
	assign hfirst  = hmatch_s1 & (~hmatch_s1 + ONE_HOT0);
	assign afirst  = after_s1 & (~after_s1 + ONE_HOT0);
	assign vfirst  = vmatch_s1 & (~vmatch_s1 + ONE_HOT0);
	assign cnt_oh  = ONE_HOT0 << cnt_q;
	assign last_oh = ONE_HOT0 << (cnt_q - CW'(1));
	assign full    = cnt_q == CW'(CAPACITY);
	assign empty   = cnt_q == '0;

	always_comb begin
		st      = ST_NOTFOUND;
		do_ins  = 1'b0;
		do_take = 1'b0;
		rd_en   = 1'b0;
		ins_oh  = cnt_oh;
		take_oh = ONE_HOT0;
		rd_oh   = ONE_HOT0;
		cnt_nx  = cnt_q;
		case (req_s1)
			REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
				if (hbad_s1) begin
					st = ST_NOTFOUND;
				end else if (|hmatch_s1) begin
					st = ST_DUP;
				end else if (full) begin
					st = ST_FULL;
				end else begin
					st     = ST_OK;
					do_ins = 1'b1;
					cnt_nx = cnt_q + CW'(1);
					if (req_s1 == REQ_PUSH_FRONT) begin
						ins_oh = ONE_HOT0;
					end else if (req_s1 == REQ_INSERT && |after_s1) begin
						ins_oh = afirst;
					end
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					st      = ST_OK;
					do_take = 1'b1;
					take_oh = (req_s1 == REQ_POP_FRONT) ? ONE_HOT0 : last_oh;
					cnt_nx  = cnt_q - CW'(1);
				end
			end
			REQ_REMOVE: begin
				if (!hbad_s1 && |hmatch_s1) begin
					st      = ST_OK;
					do_take = 1'b1;
					take_oh = hfirst;
					cnt_nx  = cnt_q - CW'(1);
				end
			end
			REQ_SEARCH: begin
				if (|vmatch_s1) begin
					st    = ST_OK;
					rd_en = 1'b1;
					rd_oh = vfirst;
				end
			end
			default: begin
				st = ST_NOTFOUND;
			end
		endcase
		if (do_take) begin
			rd_en = 1'b1;
			rd_oh = take_oh;
		end
	end

	// one-hot read of the selected cell
	always_comb begin
		oh = '0;
		ov = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			oh = oh | ({HANDLE_W{rd_en & rd_oh[i]}} & hdl_q[i]);
			ov = ov | ({VALUE_W{rd_en & rd_oh[i]}} & val_q[i]);
		end
	end

	// cells at or past the insert point move back; cells past the taken one move forward
	assign mask_le = ins_oh | (ins_oh - ONE_HOT0);
	assign mask_lt = take_oh - ONE_HOT0;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			val_nx[i] = val_q[i];
			hdl_nx[i] = hdl_q[i];
			if (do_ins) begin
				if (ins_oh[i]) begin
					val_nx[i] = val_s1;
					hdl_nx[i] = hdl_s1;
				end else if (!mask_le[i]) begin
					val_nx[i] = prv_v[i];
					hdl_nx[i] = prv_h[i];
				end
			end else if (do_take && !mask_lt[i]) begin
				val_nx[i] = nxt_v[i];
				hdl_nx[i] = nxt_h[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			val_q    <= val_nx;
			hdl_q    <= hdl_nx;
			status_q <= st;
			oh_q     <= oh;
			ov_q     <= ov;
			occ_q    <= OCC_W'(cnt_nx);
			empty_q  <= cnt_nx == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.commit) begin
			cnt_q <= cnt_nx;
		end
	end

	assign status     = status_q;
	assign out_handle = oh_q;
	assign out_value  = ov_q;
	assign occupancy  = occ_q;
	assign is_empty   = empty_q;

endmodule

// ===== rtl/core/sorted_list_deque_engine.sv =====
// Top level of the sorted list deque engine.
// Holds up to CAPACITY (handle, value) entries front to back in a chain of cells and serves one
// request at a time: push front/back, pop front/back, sorted insert, remove by handle and search
// by value. Each request runs in two steps: compare with every cell in parallel and register the
// flags, then pick the first hit and shift the chain. A new request is taken while the last
// result still waits; the update stalls only if that result has not gone by then. order_mode
// (cfg_wr_data) picks ascending (0) or descending (1) order for sorted insert; the user must
// write it only while idle (the block does not check). No clearing pass is needed after reset.
module sorted_list_deque_engine import sldq_pkg::*; #(
	parameter int CAPACITY     = 16,
	parameter int HANDLE_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [VALUE_W-1:0]  out_value,
	output logic [OCC_W-1:0]    occupancy,
	output logic                is_empty
);

	ctrl_cmd_t cmd;

	sldq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	sldq_dp #(
		.CAPACITY     (CAPACITY),
		.HANDLE_COUNT (HANDLE_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.handle      (handle),
		.value       (value),
		.status      (status),
		.out_handle  (out_handle),
		.out_value   (out_value),
		.occupancy   (occupancy),
		.is_empty    (is_empty)
	);

endmodule

// ===== dv/tb_sorted_list_deque_engine.sv =====
// Self-checking testbench for the sorted list deque engine: directed, random and back-pressure.
module tb_sorted_list_deque_engine;
	import sldq_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	typedef struct {
		status_t             st;
		logic [HANDLE_W-1:0] hnd;
		logic [VALUE_W-1:0]  val;
		logic [OCC_W-1:0]    occ;
		logic                empty;
	} list_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_wr_data = 1'b0;
	logic                in_valid = 1'b0;
	logic [REQ_W-1:0]    req_type = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [VALUE_W-1:0]  value = '0;
	logic                out_ready = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [VALUE_W-1:0]  out_value;
	logic [OCC_W-1:0]    occupancy;
	logic                is_empty;

	// shadow copy of the list, front at position 0
	logic [VALUE_W-1:0]  list_val [LIST_DEPTH];
	logic [HANDLE_W-1:0] list_hnd [LIST_DEPTH];
	int                  list_len = 0;
	bit                  order_desc = 1'b0;

	list_result_t        result_q [$];
	int                  err_count = 0;
	int                  tx_idle_pct = 20;
	int                  rx_idle_pct = 20;
	int                  rx_hold = 0;

	sorted_list_deque_engine #(
		.CAPACITY     (LIST_DEPTH),
		.HANDLE_COUNT (256)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.handle      (handle),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.out_handle  (out_handle),
		.out_value   (out_value),
		.occupancy   (occupancy),
		.is_empty    (is_empty)
	);

	always #1 clk = ~clk;

	function automatic int find_entry(input logic [HANDLE_W-1:0] h);
		int idx;
		idx = -1;
		for (int i = list_len - 1; i >= 0; i--)
			if (list_hnd[i] == h) idx = i;
		return idx;
	endfunction

	function automatic list_result_t apply_request(input logic [REQ_W-1:0] rt,
			input logic [HANDLE_W-1:0] h, input logic [VALUE_W-1:0] v);
		list_result_t r;
		int pos;
		bit hit;
		r.st  = ST_OK;
		r.hnd = '0;
		r.val = '0;
		pos   = -1;
		case (rt)
			REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT: begin
				if (find_entry(h) >= 0) r.st = ST_DUP;
				else if (list_len >= LIST_DEPTH) r.st = ST_FULL;
				else begin
					pos = (rt == REQ_PUSH_FRONT) ? 0 : list_len;
					if (rt == REQ_INSERT) begin
						hit = 1'b0;
						// first entry the order puts after the new one; ties stay behind
						for (int i = 0; i < list_len; i++)
							if (!hit && (order_desc ? (list_val[i] < v) : (list_val[i] > v))) begin
								hit = 1'b1;
								pos = i;
							end
					end
					for (int i = list_len; i > pos; i--) begin
						list_val[i] = list_val[i-1];
						list_hnd[i] = list_hnd[i-1];
					end
					list_val[pos] = v;
					list_hnd[pos] = h;
					list_len++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE: begin
				if (rt == REQ_REMOVE) pos = find_entry(h);
				else if (list_len > 0) pos = (rt == REQ_POP_FRONT) ? 0 : list_len - 1;
				if (pos < 0) r.st = (rt == REQ_REMOVE) ? ST_NOTFOUND : ST_EMPTY;
				else begin
					r.hnd = list_hnd[pos];
					r.val = list_val[pos];
					for (int i = pos; i + 1 < list_len; i++) begin
						list_val[i] = list_val[i+1];
						list_hnd[i] = list_hnd[i+1];
					end
					list_len--;
				end
			end
			REQ_SEARCH: begin
				r.st = ST_NOTFOUND;
				for (int i = list_len - 1; i >= 0; i--)
					if (list_val[i] == v) begin
						r.st  = ST_OK;
						r.hnd = list_hnd[i];
						r.val = list_val[i];
					end
			end
			default: r.st = ST_NOTFOUND;
		endcase
		r.occ   = list_len[OCC_W-1:0];
		r.empty = (list_len == 0);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_result();
		list_result_t want;
		if (result_q.size() == 0) begin
			report_mismatch("result beat with nothing outstanding");
			return;
		end
		want = result_q.pop_front();
		if (status !== want.st)
			report_mismatch($sformatf("status %0d, want %0d", status, want.st));
		if (out_handle !== want.hnd)
			report_mismatch($sformatf("out_handle %0h, want %0h", out_handle, want.hnd));
		if (out_value !== want.val)
			report_mismatch($sformatf("out_value %0h, want %0h", out_value, want.val));
		if (occupancy !== want.occ)
			report_mismatch($sformatf("occupancy %0d, want %0d", occupancy, want.occ));
		if (is_empty !== want.empty)
			report_mismatch($sformatf("is_empty %0b, want %0b", is_empty, want.empty));
	endtask

	// valid stays up from one beat to the next unless a gap is drawn
	task automatic send_req(input logic [REQ_W-1:0] rt, input logic [HANDLE_W-1:0] h,
			input logic [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		while (gap < 10 && $urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		handle   <= h;
		value    <= v;
		do @(posedge clk); while (!in_ready);
		result_q.push_back(apply_request(rt, h, v));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_order_mode(input bit desc);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= desc;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		order_desc = desc;
	endtask

	task automatic send_random_req();
		int roll;
		logic [REQ_W-1:0]    rt;
		logic [HANDLE_W-1:0] h;
		logic [VALUE_W-1:0]  v;
		roll = $urandom_range(99);
		// keep the list populated: short lists lean towards inserts
		if (list_len < 6) roll = roll / 2;
		if (roll < 30) rt = REQ_INSERT;
		else if (roll < 38) rt = REQ_PUSH_FRONT;
		else if (roll < 46) rt = REQ_PUSH_BACK;
		else if (roll < 58) rt = REQ_POP_FRONT;
		else if (roll < 68) rt = REQ_POP_BACK;
		else if (roll < 82) rt = REQ_REMOVE;
		else if (roll < 97) rt = REQ_SEARCH;
		else rt = REQ_UNUSED;

		if (rt == REQ_REMOVE && list_len > 0 && $urandom_range(99) < 70)
			h = list_hnd[$urandom_range(list_len - 1)];
		else if ($urandom_range(99) < 60)
			h = HANDLE_W'($urandom_range(23));
		else
			h = HANDLE_W'($urandom_range(255));

		if (rt == REQ_SEARCH && list_len > 0 && $urandom_range(99) < 70)
			v = list_val[$urandom_range(list_len - 1)];
		else begin
			case ($urandom_range(4))
				0, 1: v = VALUE_W'($urandom_range(7));
				2: begin
					case ($urandom_range(3))
						0: v = 32'h0000_0000;
						1: v = 32'hFFFF_FFFF;
						2: v = 32'h8000_0000;
						default: v = 32'h7FFF_FFFF;
					endcase
				end
				default: v = $urandom;
			endcase
		end
		send_req(rt, h, v);
	endtask

	task automatic run_random_phase(input int n, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n) send_random_req();
	endtask

	task automatic test_empty_list();
		send_req(REQ_POP_FRONT, 8'h00, 32'h0);
		send_req(REQ_POP_BACK, 8'hFF, 32'hFFFF_FFFF);
		send_req(REQ_REMOVE, 8'h5A, 32'h0);
		send_req(REQ_UNUSED, 8'hA5, 32'h1234_5678);
	endtask

	task automatic test_fill_and_full();
		logic [VALUE_W-1:0] v;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (i == 0) v = 32'h0000_0000;
			else if (i == LIST_DEPTH - 1) v = 32'hFFFF_FFFF;
			else v = (i % 4 == 0) ? 32'h8000_0000 : $urandom;
			case (i % 3)
				0: send_req(REQ_INSERT, 8'(i * 17), v);
				1: send_req(REQ_PUSH_FRONT, 8'(i * 17), v);
				default: send_req(REQ_PUSH_BACK, 8'(i * 17), v);
			endcase
		end
		send_req(REQ_PUSH_BACK, 8'hC8, 32'h55AA_55AA);   // full
		send_req(REQ_INSERT, 8'h00, 32'h1);              // duplicate wins over full
		send_req(REQ_SEARCH, 8'h00, 32'h0000_0000);
		send_req(REQ_SEARCH, 8'h00, 32'h0BAD_F00D);
		send_req(REQ_REMOVE, 8'(5 * 17), 32'h0);
		send_req(REQ_POP_FRONT, 8'h00, 32'h0);
		send_req(REQ_POP_BACK, 8'h00, 32'h0);
	endtask

	task automatic test_order_modes();
		set_order_mode(1'b1);
		run_random_phase(130, 38, 66);
		set_order_mode(1'b0);
		run_random_phase(130, 66, 38);
		set_order_mode(1'b1);
		run_random_phase(100, 0, 0);
	endtask

	// output held off long enough that the engine fills and drops in_ready
	task automatic test_backpressure();
		set_order_mode(1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 80;
		repeat (30) send_random_req();
	endtask

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) check_result();
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_fill_and_full();
		test_order_modes();
		test_backpressure();
		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#200000;
		$display("FAIL");
		$finish;
	end

endmodule
